/* hw/rtl/btn_pkg.sv */
// Shared constants, register codes and record types for the bilinear neighborhood core.
`timescale 1ns / 1ps
package btn_pkg;
	localparam int TILES_X     = 8;
	localparam int TILES_Y     = 8;
	localparam int MAX_OUT_DIM = 4096;
	localparam int MAX_IN_DIM  = 4096;

	localparam int COORD_W  = 12;
	localparam int DIM_W    = 13;
	localparam int IDX_W    = 24;
	localparam int WT_W     = 17;
	localparam int MISS_W   = 3;
	localparam int FRAC_W   = 16;
	localparam int STEP_W   = 32;
	localparam int PROD_W   = COORD_W + STEP_W;
	localparam int CX_W     = PROD_W + 3;
	localparam int POS_W    = 32;
	localparam int LOG2_W   = 4;
	localparam int MASK_W   = 64;
	localparam int TBIT_W   = 6;
	localparam int NBR      = 4;
	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = 2;
	localparam int HALF_Q16 = 32768;
	localparam logic [WT_W-1:0] ONE_Q16 = 17'd65536;

	localparam int APB_DATA_W = 64;
	localparam int APB_ADDR_W = 6;
	localparam int REG_IDX_W  = 3;
	localparam logic [REG_IDX_W-1:0] REG_MODE      = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_STEP      = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_IN_WIDTH  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_IN_HEIGHT = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_TILE_LOG2 = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_PRESENT   = 3'd7;

	typedef struct packed {
		logic                     mode;
		logic signed [POS_W-1:0]  origin_x;
		logic signed [POS_W-1:0]  origin_y;
		logic [STEP_W-1:0]        step;
		logic [DIM_W-1:0]         w_eff;
		logic [DIM_W-1:0]         h_eff;
		logic [LOG2_W-1:0]        tile_log2;
		logic [MASK_W-1:0]        present;
	} cfg_t;

	typedef struct packed {
		logic [COORD_W-1:0]            col;
		logic [COORD_W-1:0]            row;
		logic [NBR-1:0]                pres;
		logic [NBR-1:0][IDX_W-1:0]     idx;
		logic [NBR-1:0][WT_W-1:0]      wt;
		logic [MISS_W-1:0]             missing;
	} rec_t;
endpackage

/* hw/rtl/btn_chan_if.sv */
// Valid/ready channel interfaces for pixel requests and neighbor results.
`timescale 1ns / 1ps
interface btn_in_if import btn_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] out_col;
	logic [COORD_W-1:0] out_row;

	modport source (output valid, output out_col, output out_row, input ready);
	modport sink (input valid, input out_col, input out_row, output ready);
endinterface

interface btn_out_if import btn_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] col_echo;
	logic [COORD_W-1:0] row_echo;
	logic               sample_valid;
	logic [IDX_W-1:0]   src_index;
	logic [WT_W-1:0]    weight;
	logic [MISS_W-1:0]  missing_count;
	logic               last;

	modport source (output valid, output col_echo, output row_echo, output sample_valid,
		output src_index, output weight, output missing_count, output last, input ready);
	modport sink (input valid, input col_echo, input row_echo, input sample_valid,
		input src_index, input weight, input missing_count, input last, output ready);
endinterface

/* hw/rtl/btn_cfg.sv */
// APB register file holding the grid, image and tile configuration.
`timescale 1ns / 1ps
module btn_cfg import btn_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);
	logic                    mode_q;
	logic signed [POS_W-1:0] origin_x_q;
	logic signed [POS_W-1:0] origin_y_q;
	logic [STEP_W-1:0]       step_q;
	logic [DIM_W-1:0]        in_width_q;
	logic [DIM_W-1:0]        in_height_q;
	logic [LOG2_W-1:0]       tile_log2_q;
	logic [MASK_W-1:0]       present_q;
	logic [REG_IDX_W-1:0]    reg_idx;
	logic                    wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_ADDR_W-1:3];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= 1'b0;
			origin_x_q  <= '0;
			origin_y_q  <= '0;
			step_q      <= 32'd65536;
			in_width_q  <= DIM_W'(MAX_IN_DIM);
			in_height_q <= DIM_W'(MAX_IN_DIM);
			tile_log2_q <= 4'd6;
			present_q   <= '1;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_MODE:      mode_q      <= pwdata[0];
				REG_ORIGIN_X:  origin_x_q  <= signed'(pwdata[POS_W-1:0]);
				REG_ORIGIN_Y:  origin_y_q  <= signed'(pwdata[POS_W-1:0]);
				REG_STEP:      step_q      <= pwdata[STEP_W-1:0];
				REG_IN_WIDTH:  in_width_q  <= pwdata[DIM_W-1:0];
				REG_IN_HEIGHT: in_height_q <= pwdata[DIM_W-1:0];
				REG_TILE_LOG2: tile_log2_q <= pwdata[LOG2_W-1:0];
				REG_PRESENT:   present_q   <= pwdata[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MODE:      prdata = APB_DATA_W'(mode_q);
			REG_ORIGIN_X:  prdata = APB_DATA_W'(unsigned'(origin_x_q));
			REG_ORIGIN_Y:  prdata = APB_DATA_W'(unsigned'(origin_y_q));
			REG_STEP:      prdata = APB_DATA_W'(step_q);
			REG_IN_WIDTH:  prdata = APB_DATA_W'(in_width_q);
			REG_IN_HEIGHT: prdata = APB_DATA_W'(in_height_q);
			REG_TILE_LOG2: prdata = APB_DATA_W'(tile_log2_q);
			REG_PRESENT:   prdata = APB_DATA_W'(present_q);
			default:       prdata = '0;
		endcase
	end

	// clamp image size to the largest supported dimension
	always_comb begin
		cfg.mode      = mode_q;
		cfg.origin_x  = origin_x_q;
		cfg.origin_y  = origin_y_q;
		cfg.step      = step_q;
		cfg.w_eff     = (in_width_q > DIM_W'(MAX_IN_DIM)) ? DIM_W'(MAX_IN_DIM) : in_width_q;
		cfg.h_eff     = (in_height_q > DIM_W'(MAX_IN_DIM)) ? DIM_W'(MAX_IN_DIM) : in_height_q;
		cfg.tile_log2 = tile_log2_q;
		cfg.present   = present_q;
	end
endmodule

/* hw/rtl/btn_front.sv */
// Front pipeline: maps a pixel to its neighbors, weights, presence and flat indices.
`timescale 1ns / 1ps
module btn_front import btn_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	btn_in_if.sink in_ch,
	input  logic q_full,
	output logic push,
	output rec_t push_rec
);
	logic adv;
	logic accept;
	logic in_range;
	logic v_s1, v_s2, v_s3, v_s4;

	logic [COORD_W-1:0] col_s1, row_s1, col_s2, row_s2, col_s3, row_s3;
	logic [PROD_W-1:0]  px_s1, py_s1;

	logic signed [CX_W-1:0]  cx_c, cy_c, ux_c, uy_c;
	logic signed [POS_W-1:0] j0_s2, k0_s2;
	logic [FRAC_W-1:0]       fx_s2, fy_s2;
	logic                    mode_s2;

	logic signed [POS_W-1:0]   nx_c [NBR];
	logic signed [POS_W-1:0]   ny_c [NBR];
	logic [COORD_W-1:0]        tx_c [NBR];
	logic [COORD_W-1:0]        ty_c [NBR];
	logic [TBIT_W-1:0]         tbit_c [NBR];
	logic [NBR-1:0]            cand_c, pres_c;
	logic [NBR-1:0][WT_W-1:0]  wt_c;
	logic [WT_W-1:0]           gx_c, gy_c;
	logic [1:0][IDX_W-1:0]     rp_c;
	logic [NBR-1:0]            cand_s3, pres_s3;
	logic [NBR-1:0][WT_W-1:0]  wt_s3;
	logic [1:0][IDX_W-1:0]     rp_s3;
	logic [1:0][COORD_W-1:0]   xlo_s3;

	rec_t             rec_c, rec_s4;
	logic [MISS_W-1:0] miss_c;

	// whole pipeline holds while the last stage cannot transfer into the queue
	assign adv         = !v_s4 || !q_full;
	assign in_ch.ready = adv;
	assign accept      = in_ch.valid && adv;
	assign in_range    = ({1'b0, in_ch.out_col} < (COORD_W+1)'(MAX_OUT_DIM)) &&
	                     ({1'b0, in_ch.out_row} < (COORD_W+1)'(MAX_OUT_DIM));
	assign push        = v_s4 && !q_full;
	assign push_rec    = rec_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept && in_range;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// stage 1: position products
	always_ff @(posedge clk) begin
		if (adv) begin
			col_s1 <= in_ch.out_col;
			row_s1 <= in_ch.out_row;
			px_s1  <= PROD_W'(in_ch.out_col) * PROD_W'(cfg.step);
			py_s1  <= PROD_W'(in_ch.out_row) * PROD_W'(cfg.step);
		end
	end

	// stage 2: add origin, shift by half a pixel in bilinear mode, split floor and fraction
	always_comb begin
		cx_c = CX_W'(cfg.origin_x) + signed'(CX_W'(px_s1));
		cy_c = CX_W'(cfg.origin_y) + signed'(CX_W'(py_s1));
		ux_c = cfg.mode ? cx_c : cx_c - CX_W'(HALF_Q16);
		uy_c = cfg.mode ? cy_c : cy_c - CX_W'(HALF_Q16);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			col_s2  <= col_s1;
			row_s2  <= row_s1;
			mode_s2 <= cfg.mode;
			j0_s2   <= POS_W'(signed'(ux_c[CX_W-1:FRAC_W]));
			k0_s2   <= POS_W'(signed'(uy_c[CX_W-1:FRAC_W]));
			fx_s2   <= cfg.mode ? '0 : ux_c[FRAC_W-1:0];
			fy_s2   <= cfg.mode ? '0 : uy_c[FRAC_W-1:0];
		end
	end

	// stage 3: per-neighbor bounds, tile lookup, weights and row products
	always_comb begin
		logic [WT_W-1:0]     wa, wb;
		logic [2*WT_W-1:0]   prod;
		logic                in_img, tile_ok;
		gx_c = ONE_Q16 - {1'b0, fx_s2};
		gy_c = ONE_Q16 - {1'b0, fy_s2};
		for (int n = 0; n < NBR; n++) begin
			nx_c[n] = (n % 2 == 1) ? j0_s2 + 32'sd1 : j0_s2;
			ny_c[n] = (n / 2 == 1) ? k0_s2 + 32'sd1 : k0_s2;
			in_img  = (nx_c[n] >= 32'sd0) && (nx_c[n] < signed'(POS_W'(cfg.w_eff))) &&
			          (ny_c[n] >= 32'sd0) && (ny_c[n] < signed'(POS_W'(cfg.h_eff)));
			tx_c[n] = nx_c[n][COORD_W-1:0] >> cfg.tile_log2;
			ty_c[n] = ny_c[n][COORD_W-1:0] >> cfg.tile_log2;
			tile_ok = (tx_c[n] < COORD_W'(TILES_X)) && (ty_c[n] < COORD_W'(TILES_Y));
			tbit_c[n] = TBIT_W'(ty_c[n]) * TBIT_W'(TILES_X) + TBIT_W'(tx_c[n]);
			cand_c[n] = !mode_s2 || (n == 0);
			pres_c[n] = cand_c[n] && in_img && tile_ok && cfg.present[tbit_c[n]];
			wa = (n % 2 == 1) ? {1'b0, fx_s2} : gx_c;
			wb = (n / 2 == 1) ? {1'b0, fy_s2} : gy_c;
			prod = (2*WT_W)'(wa) * (2*WT_W)'(wb);
			// round to nearest, halves up
			wt_c[n] = WT_W'((prod + (2*WT_W)'(HALF_Q16)) >> FRAC_W);
		end
		for (int r = 0; r < 2; r++) begin
			rp_c[r] = IDX_W'((COORD_W+DIM_W)'(ny_c[2*r][COORD_W-1:0]) *
			                 (COORD_W+DIM_W)'(cfg.w_eff));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			col_s3    <= col_s2;
			row_s3    <= row_s2;
			cand_s3   <= cand_c;
			pres_s3   <= pres_c;
			wt_s3     <= wt_c;
			rp_s3     <= rp_c;
			xlo_s3[0] <= nx_c[0][COORD_W-1:0];
			xlo_s3[1] <= nx_c[1][COORD_W-1:0];
		end
	end

	// stage 4: flat indices and missing count
	always_comb begin
		miss_c = '0;
		for (int n = 0; n < NBR; n++) begin
			miss_c = miss_c + MISS_W'(cand_s3[n] && !pres_s3[n]);
		end
		rec_c.col     = col_s3;
		rec_c.row     = row_s3;
		rec_c.pres    = pres_s3;
		rec_c.wt      = wt_s3;
		rec_c.missing = miss_c;
		for (int n = 0; n < NBR; n++) begin
			rec_c.idx[n] = rp_s3[n / 2] + IDX_W'(xlo_s3[n % 2]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rec_s4 <= rec_c;
		end
	end
endmodule

/* hw/rtl/btn_queue.sv */
// Short record queue between the front pipeline and the result sequencer.
`timescale 1ns / 1ps
module btn_queue import btn_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rec_t push_rec,
	output logic full,
	input  logic pop,
	output rec_t head,
	output logic empty
);
	rec_t              mem [QDEPTH];
	logic [QPTR_W-1:0] wptr_q, rptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign full  = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QPTR_W+1)'(QDEPTH)) else $error("queue count beyond depth");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("push into full queue");
	a_pop_data: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("pop from empty queue");
	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count did not advance");
endmodule

/* hw/rtl/btn_back.sv */
// Result sequencer: one present head neighbor per cycle while output is ready.
`timescale 1ns / 1ps
module btn_back import btn_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  rec_t head,
	input  logic empty,
	output logic pop,
	btn_out_if.source out_ch
);
	logic [NBR-1:0]   done_q;
	logic [NBR-1:0]   rem_c, pick_m;
	logic [1:0]       pick_i;
	logic             emit, last_c;

	logic               ov_q;
	logic [COORD_W-1:0] col_q, row_q;
	logic               sv_q;
	logic [IDX_W-1:0]   idx_q;
	logic [WT_W-1:0]    wt_q;
	logic [MISS_W-1:0]  miss_q;
	logic               last_q;

	// lowest remaining present neighbor goes first
	always_comb begin
		rem_c  = head.pres & ~done_q;
		pick_i = '0;
		for (int n = NBR - 1; n >= 0; n--) begin
			if (rem_c[n]) begin
				pick_i = 2'(n);
			end
		end
		pick_m = NBR'(1) << pick_i;
		if (rem_c == '0) begin
			pick_m = '0;
		end
		last_c = ((rem_c & ~pick_m) == '0);
	end

	assign emit = !empty && (!ov_q || out_ch.ready);
	assign pop  = emit && last_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q   <= 1'b0;
			done_q <= '0;
		end else begin
			if (emit) begin
				ov_q   <= 1'b1;
				done_q <= last_c ? '0 : (done_q | pick_m);
			end else if (out_ch.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			col_q  <= head.col;
			row_q  <= head.row;
			sv_q   <= (rem_c != '0);
			idx_q  <= (rem_c != '0) ? head.idx[pick_i] : '0;
			wt_q   <= (rem_c != '0) ? head.wt[pick_i] : '0;
			miss_q <= head.missing;
			last_q <= last_c;
		end
	end

	assign out_ch.valid         = ov_q;
	assign out_ch.col_echo      = col_q;
	assign out_ch.row_echo      = row_q;
	assign out_ch.sample_valid  = sv_q;
	assign out_ch.src_index     = idx_q;
	assign out_ch.weight        = wt_q;
	assign out_ch.missing_count = miss_q;
	assign out_ch.last          = last_q;

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && !sv_q |-> last_q) else $error("empty result not marked last");
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && !sv_q |-> idx_q == '0 && wt_q == '0) else $error("empty result carries data");
	a_miss_range: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q |-> miss_q <= MISS_W'(NBR)) else $error("missing count out of range");
	a_done_clear: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> done_q == '0) else $error("neighbor mask not cleared after last");
endmodule

/* hw/rtl/bilinear_tile_neighborhood_core.sv */
// A request passes front stages 1 to 4, then the record queue, then the result register.
// Throughput: one result per cycle while the output is ready, and a pixel in range gives 1 to 4 results;
//   a new request is taken every cycle while the four-entry record queue has room.
// The result sequencer, one neighbor per cycle while the output is ready, sets the sustained pixel rate.
// Reset (arst_n low, asynchronous): pipeline, queue and output empty, registers to defaults.
`timescale 1ns / 1ps
module bilinear_tile_neighborhood_core import btn_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	btn_in_if.sink                in_ch,
	btn_out_if.source             out_ch
);
	cfg_t cfg;
	logic push, q_full, pop, q_empty;
	rec_t push_rec, head;

	btn_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	btn_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_ch    (in_ch),
		.q_full   (q_full),
		.push     (push),
		.push_rec (push_rec)
	);

	btn_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.full     (q_full),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty)
	);

	btn_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (q_empty),
		.pop    (pop),
		.out_ch (out_ch)
	);
endmodule
